/* src/frkt_pkg.sv */
// ----------------------------------------------------------------------------
// frkt_pkg
// Shared types and constants of the frequency-ranked key table.
// ----------------------------------------------------------------------------
`default_nettype none

package frkt_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned CountBitsDef  = 16;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned UseCntW  = 16;
  localparam int unsigned TotalW   = 32;

  typedef enum logic [0:0] {
    REQ_UPDATE = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    ST_HIT      = 3'd0,
    ST_INSERT   = 3'd1,
    ST_RECYCLE  = 3'd2,
    ST_DROP     = 3'd3,
    ST_FOUND    = 3'd4,
    ST_MISS     = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_WRA  = 5'b00100,
    S_WRB  = 5'b01000,
    S_PUSH = 5'b10000
  } state_e;

endpackage

`default_nettype wire

/* src/frkt_req_if.sv */
// ----------------------------------------------------------------------------
// frkt_req_if
// Request channel: request type and key with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface frkt_req_if import frkt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [KeyW-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

`default_nettype wire

/* src/frkt_rsp_if.sv */
// ----------------------------------------------------------------------------
// frkt_rsp_if
// Response channel: status, slot, count and update total with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface frkt_rsp_if import frkt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   slot_index;
  logic [UseCntW-1:0] use_count;
  logic [TotalW-1:0]  update_total;

  modport source (output valid, output status, output slot_index, output use_count,
                  output update_total, input ready);
  modport sink   (input valid, input status, input slot_index, input use_count,
                  input update_total, output ready);
endinterface

`default_nettype wire

/* src/frkt_ram.sv */
// ----------------------------------------------------------------------------
// frkt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frkt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/frequency_ranked_key_table.sv */
// ----------------------------------------------------------------------------
// frequency_ranked_key_table
// Table of keys with use counts, kept in descending count order in one RAM.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Payload
//  req_i     in   valid/ready      req_type, key
//  rsp_o     out  valid/ready      status, slot_index, use_count, update_total
//  cfg       in   cfg_we_i only    cfg_wdata_i (slots in use)
//
//  One request at a time: the scan reads the occupied slots in use, one RAM
//  read per cycle, up to the match, else every one of them. A lookup or a
//  dropped update then goes to the response register; any other update first
//  passes the write-back state S_WRA, and a hit that swaps also S_WRB.
//  Reset empties the table at once through the fill count; no clearing pass.
//  A request may be accepted while the previous response still waits; the
//  scan result is held until the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_ranked_key_table import frkt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  frkt_req_if.sink             req_i,
  frkt_rsp_if.source           rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW   = $clog2(TABLE_DEPTH);
  localparam int unsigned NumW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RegW   = (NumW > CfgW) ? NumW : CfgW;
  localparam int unsigned EntW   = KeyW + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  state_e                state_q, state_d;
  logic [RegW-1:0]       cfg_q;
  logic [NumW-1:0]       fill_q, fill_d;
  logic [TotalW-1:0]     updates_q, updates_d;
  logic                  lookup_q, lookup_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic [NumW-1:0]       n_q, n_d, lim_q, lim_d;
  logic [NumW-1:0]       iss_q, iss_d;
  logic [IdxW-1:0]       chk_q, chk_d;
  logic                  dv_q, dv_d;
  logic [COUNT_BITS-1:0] prev_cnt_q, prev_cnt_d;
  logic [IdxW-1:0]       run_start_q, run_start_d;
  logic [KeyW-1:0]       run_key_q, run_key_d;
  logic                  wa_en_q, wa_en_d, wb_en_q, wb_en_d;
  logic [IdxW-1:0]       wa_addr_q, wa_addr_d, wb_addr_q, wb_addr_d;
  logic [EntW-1:0]       wa_data_q, wa_data_d, wb_data_q, wb_data_d;
  status_e               res_status_q, res_status_d;
  logic [IdxW-1:0]       res_slot_q, res_slot_d;
  logic [COUNT_BITS-1:0] res_cnt_q, res_cnt_d;
  logic                  rsp_valid_q, rsp_valid_d;
  logic [StatusW-1:0]    rsp_status_q, rsp_status_d;
  logic [SlotW-1:0]      rsp_slot_q, rsp_slot_d;
  logic [UseCntW-1:0]    rsp_cnt_q, rsp_cnt_d;
  logic [TotalW-1:0]     rsp_total_q, rsp_total_d;

  logic                  req_fire;
  logic [NumW-1:0]       n_c, lim_c;
  logic                  ram_we, ram_re;
  logic [IdxW-1:0]       ram_waddr;
  logic [EntW-1:0]       ram_wdata, ram_rdata;
  logic [KeyW-1:0]       rd_key;
  logic [COUNT_BITS-1:0] rd_cnt, cnt_inc;
  logic                  match, is_last, run_new;
  logic [IdxW-1:0]       start_now;
  logic [KeyW-1:0]       rkey_now;
  logic [31:0]           slot_ext, cnt_ext;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // Effective slots in use: zero acts as one, anything above the depth as the depth.
  assign n_c = (cfg_q == '0) ? NumW'(1) :
               (cfg_q > RegW'(TABLE_DEPTH)) ? NumW'(TABLE_DEPTH) : NumW'(cfg_q);
  // Occupied slots always form a prefix, so the scan stops at the fill count or the slots in use, whichever is lower.
  assign lim_c = (fill_q < n_c) ? fill_q : n_c;

  assign ram_re    = (state_q == S_SCAN) && (iss_q < lim_q);
  assign ram_we    = ((state_q == S_WRA) && wa_en_q) || ((state_q == S_WRB) && wb_en_q);
  assign ram_waddr = (state_q == S_WRB) ? wb_addr_q : wa_addr_q;
  assign ram_wdata = (state_q == S_WRB) ? wb_data_q : wa_data_q;

  frkt_ram #(
    .Width (EntW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_key  = ram_rdata[EntW-1 -: KeyW];
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];
  assign cnt_inc = (rd_cnt == CntMax) ? rd_cnt : rd_cnt + CntOne;
  assign match   = dv_q && (rd_key == key_q);
  assign is_last = dv_q && (NumW'(chk_q) == lim_q - NumW'(1));

  // Track the first slot of the current run of equal counts. Since the order is
  // descending, that slot is the first one whose count is below the new count.
  assign run_new   = (chk_q == '0) || (rd_cnt != prev_cnt_q);
  assign start_now = run_new ? chk_q : run_start_q;
  assign rkey_now  = run_new ? rd_key : run_key_q;

  assign slot_ext = 32'(res_slot_q);
  assign cnt_ext  = 32'(res_cnt_q);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    updates_d    = updates_q;
    lookup_d     = lookup_q;
    key_d        = key_q;
    n_d          = n_q;
    lim_d        = lim_q;
    iss_d        = iss_q;
    chk_d        = chk_q;
    dv_d         = dv_q;
    prev_cnt_d   = prev_cnt_q;
    run_start_d  = run_start_q;
    run_key_d    = run_key_q;
    wa_en_d      = wa_en_q;
    wa_addr_d    = wa_addr_q;
    wa_data_d    = wa_data_q;
    wb_en_d      = wb_en_q;
    wb_addr_d    = wb_addr_q;
    wb_data_d    = wb_data_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_cnt_d    = res_cnt_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_slot_d   = rsp_slot_q;
    rsp_cnt_d    = rsp_cnt_q;
    rsp_total_d  = rsp_total_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          lookup_d = (req_i.req_type == REQ_LOOKUP);
          key_d    = req_i.key;
          n_d      = n_c;
          lim_d    = lim_c;
          iss_d    = '0;
          dv_d     = 1'b0;
          wa_en_d  = 1'b0;
          wb_en_d  = 1'b0;
          if (req_i.req_type == REQ_UPDATE) begin
            updates_d = updates_q + TotalW'(1);
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        dv_d  = ram_re;
        chk_d = iss_q[IdxW-1:0];
        if (ram_re) begin
          iss_d = iss_q + NumW'(1);
        end
        if (dv_q) begin
          prev_cnt_d  = rd_cnt;
          run_start_d = start_now;
          run_key_d   = rkey_now;
        end
        if (match) begin
          res_slot_d = chk_q;
          if (lookup_q) begin
            res_status_d = ST_FOUND;
            res_cnt_d    = rd_cnt;
            state_d      = S_PUSH;
          end else begin
            res_status_d = ST_HIT;
            res_cnt_d    = cnt_inc;
            state_d      = S_WRA;
            if (rd_cnt != CntMax) begin
              wa_en_d   = 1'b1;
              wa_addr_d = chk_q;
              if (start_now != chk_q) begin
                wa_data_d = {rkey_now, rd_cnt};
                wb_en_d   = 1'b1;
                wb_addr_d = start_now;
                wb_data_d = {key_q, cnt_inc};
              end else begin
                wa_data_d = {key_q, cnt_inc};
              end
            end
          end
        end else if ((lim_q == '0) || is_last) begin
          res_slot_d = '0;
          res_cnt_d  = '0;
          if (lookup_q) begin
            res_status_d = ST_MISS;
            state_d      = S_PUSH;
          end else if (lim_q < n_q) begin
            res_status_d = ST_INSERT;
            res_slot_d   = lim_q[IdxW-1:0];
            res_cnt_d    = CntOne;
            wa_en_d      = 1'b1;
            wa_addr_d    = lim_q[IdxW-1:0];
            wa_data_d    = {key_q, CntOne};
            fill_d       = fill_q + NumW'(1);
            state_d      = S_WRA;
          end else if (rd_cnt == CntOne) begin
            // Table full and the last slot seen only once: it takes the new key.
            res_status_d = ST_RECYCLE;
            res_slot_d   = chk_q;
            res_cnt_d    = CntOne;
            wa_en_d      = 1'b1;
            wa_addr_d    = chk_q;
            wa_data_d    = {key_q, CntOne};
            state_d      = S_WRA;
          end else begin
            res_status_d = ST_DROP;
            state_d      = S_PUSH;
          end
        end
      end
      S_WRA: begin
        state_d = wb_en_q ? S_WRB : S_PUSH;
      end
      S_WRB: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_slot_d   = slot_ext[SlotW-1:0];
          rsp_cnt_d    = cnt_ext[UseCntW-1:0];
          rsp_total_d  = updates_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= RegW'(TABLE_DEPTH);
      fill_q      <= '0;
      updates_q   <= '0;
      dv_q        <= 1'b0;
      wa_en_q     <= 1'b0;
      wb_en_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      updates_q   <= updates_d;
      dv_q        <= dv_d;
      wa_en_q     <= wa_en_d;
      wb_en_q     <= wb_en_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        cfg_q <= RegW'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lookup_q     <= lookup_d;
    key_q        <= key_d;
    n_q          <= n_d;
    lim_q        <= lim_d;
    iss_q        <= iss_d;
    chk_q        <= chk_d;
    prev_cnt_q   <= prev_cnt_d;
    run_start_q  <= run_start_d;
    run_key_q    <= run_key_d;
    wa_addr_q    <= wa_addr_d;
    wa_data_q    <= wa_data_d;
    wb_addr_q    <= wb_addr_d;
    wb_data_q    <= wb_data_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_cnt_q    <= res_cnt_d;
    rsp_status_q <= rsp_status_d;
    rsp_slot_q   <= rsp_slot_d;
    rsp_cnt_q    <= rsp_cnt_d;
    rsp_total_q  <= rsp_total_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.slot_index   = rsp_slot_q;
  assign rsp_o.use_count    = rsp_cnt_q;
  assign rsp_o.update_total = rsp_total_q;

endmodule

`default_nettype wire

/* src/frkt_checker.sv */
// ----------------------------------------------------------------------------
// frkt_checker
// Port-level checks of the frequency-ranked key table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frkt_checker import frkt_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid_i,
  input wire logic               req_ready_i,
  input wire logic               rsp_valid_i,
  input wire logic               rsp_ready_i,
  input wire logic [StatusW-1:0] status_i,
  input wire logic [SlotW-1:0]   slot_index_i,
  input wire logic [UseCntW-1:0] use_count_i
);

  // A stalled response keeps its valid.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response valid dropped while stalled");

  // Requests are worked one at a time, so acceptance closes the request side.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in progress");

  // A miss or a drop reports neither a slot nor a count.
  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_MISS || status_i == ST_DROP)
      |-> slot_index_i == '0 && use_count_i == '0)
    else $error("miss or drop carries a slot or count");

  // A freshly written key always starts with a count of one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_INSERT || status_i == ST_RECYCLE)
      |-> use_count_i == UseCntW'(1))
    else $error("inserted key reported with a count other than one");

endmodule

bind frequency_ranked_key_table frkt_checker u_frkt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .slot_index_i (rsp_o.slot_index),
  .use_count_i  (rsp_o.use_count)
);

`default_nettype wire
